// ----- src/aligned_block_match_merger_defines.svh -----
// assertion macros shared by the aligned block match merger modules
`ifndef ALIGNED_BLOCK_MATCH_MERGER_DEFINES_SVH
`define ALIGNED_BLOCK_MATCH_MERGER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ABMM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ABMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/abmm_pkg.sv -----
// shared types and constants of the aligned block match merger
package abmm_pkg;

	localparam int unsigned MAX_BLOCK_DEF = 256;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_SCAN = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [31:0] run_offset;
		logic [31:0] run_size;
		logic [31:0] run_blocks;
		logic        scan_done;
		logic        no_run;
	} res_t;

endpackage

// ----- src/abmm_ref_store.sv -----
// reference byte memory with one write port and a registered prefetch read
module abmm_ref_store #(
	parameter int unsigned MAX_BLOCK = abmm_pkg::MAX_BLOCK_DEF,
	parameter int unsigned ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);
	import abmm_pkg::*;

	logic [7:0] mem [MAX_BLOCK];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a byte written in the same cycle as it is fetched is forwarded
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == rd_addr) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/abmm_match_core.sv -----
// chunk compare, run merge and scan state of the aligned block match merger
`include "aligned_block_match_merger_defines.svh"

module abmm_match_core #(
	parameter int unsigned MAX_BLOCK = abmm_pkg::MAX_BLOCK_DEF,
	parameter int unsigned ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
	parameter int unsigned CNT_W = $clog2(MAX_BLOCK + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              present,
	input  logic              fire,
	input  logic              command,
	input  logic [7:0]        data_byte,
	input  logic              last,
	input  logic [7:0]        ref_byte,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [7:0]        wr_data,
	output logic [ADDR_W-1:0] rd_addr,
	output logic              has_result,
	output abmm_pkg::res_t    res
);
	import abmm_pkg::*;

	logic [CNT_W-1:0] ref_len_q, ref_len_n;
	logic             ref_done_q, ref_done_n;
	logic [CNT_W-1:0] chunk_pos_q, chunk_pos_n;
	logic             mismatch_q, mismatch_n;
	logic [31:0]      offset_q, offset_n;
	logic             run_active_q, run_active_n;
	logic [31:0]      run_start_q, run_start_n;
	logic [31:0]      run_len_q, run_len_n;
	logic [31:0]      run_chunks_q, run_chunks_n;

	logic [CNT_W-1:0] base_len;
	logic             room;
	logic             has_ref;
	logic [CNT_W-1:0] pos1;
	logic [32:0]      len_sum;
	logic             mm;
	logic             wr_req;

	// a load after a completed reference starts over at length zero
	assign base_len = ref_done_q ? '0 : ref_len_q;
	assign room     = base_len < CNT_W'(MAX_BLOCK);
	assign has_ref  = ref_len_q != '0;
	assign pos1     = chunk_pos_q + CNT_W'(1);
	assign len_sum  = {1'b0, run_len_q} + 33'(pos1);

	always_comb begin
		ref_len_n    = ref_len_q;
		ref_done_n   = ref_done_q;
		chunk_pos_n  = chunk_pos_q;
		mismatch_n   = mismatch_q;
		offset_n     = offset_q;
		run_active_n = run_active_q;
		run_start_n  = run_start_q;
		run_len_n    = run_len_q;
		run_chunks_n = run_chunks_q;
		mm           = mismatch_q;
		wr_req       = 1'b0;
		has_result   = 1'b0;
		res          = '0;
		if (present) begin
			if (command == CMD_LOAD) begin
				wr_req       = room;
				ref_len_n    = base_len + CNT_W'(room);
				ref_done_n   = last;
				chunk_pos_n  = '0;
				mismatch_n   = 1'b0;
				offset_n     = '0;
				run_active_n = 1'b0;
				run_start_n  = '0;
				run_len_n    = '0;
				run_chunks_n = '0;
			end else begin
				if (has_ref) begin
					if (chunk_pos_q == '0 && !run_active_q) begin
						run_start_n = offset_q;
					end
					mm          = mismatch_q | (ref_byte != data_byte);
					chunk_pos_n = pos1;
					mismatch_n  = mm;
				end
				offset_n = (offset_q == SAT32) ? SAT32 : offset_q + 32'd1;
				// chunk boundary: full chunk or short final chunk
				if (has_ref && (pos1 >= ref_len_q || last)) begin
					if (!mm) begin
						if (run_active_q) begin
							run_len_n    = len_sum[32] ? SAT32 : len_sum[31:0];
							run_chunks_n = (run_chunks_q == SAT32) ? SAT32
								: run_chunks_q + 32'd1;
						end else begin
							run_active_n = 1'b1;
							run_len_n    = 32'(pos1);
							run_chunks_n = 32'd1;
						end
					end else if (run_active_q) begin
						has_result     = 1'b1;
						res.run_offset = run_start_q;
						res.run_size   = run_len_q;
						res.run_blocks = run_chunks_q;
						res.scan_done  = last;
						res.no_run     = 1'b0;
						run_active_n   = 1'b0;
					end
					chunk_pos_n = '0;
					mismatch_n  = 1'b0;
				end
				if (last) begin
					if (!has_result) begin
						has_result    = 1'b1;
						res.scan_done = 1'b1;
						res.no_run    = !run_active_n;
						if (run_active_n) begin
							res.run_offset = run_start_n;
							res.run_size   = run_len_n;
							res.run_blocks = run_chunks_n;
						end
					end
					chunk_pos_n  = '0;
					mismatch_n   = 1'b0;
					offset_n     = '0;
					run_active_n = 1'b0;
					run_start_n  = '0;
					run_len_n    = '0;
					run_chunks_n = '0;
				end
			end
		end
	end

	assign wr_en   = fire && wr_req;
	assign wr_addr = base_len[ADDR_W-1:0];
	assign wr_data = data_byte;
	// prefetch the reference byte the next scan transaction compares against
	assign rd_addr = fire ? chunk_pos_n[ADDR_W-1:0] : chunk_pos_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q    <= '0;
			ref_done_q   <= 1'b0;
			chunk_pos_q  <= '0;
			mismatch_q   <= 1'b0;
			offset_q     <= '0;
			run_active_q <= 1'b0;
			run_start_q  <= '0;
			run_len_q    <= '0;
			run_chunks_q <= '0;
		end else if (fire) begin
			ref_len_q    <= ref_len_n;
			ref_done_q   <= ref_done_n;
			chunk_pos_q  <= chunk_pos_n;
			mismatch_q   <= mismatch_n;
			offset_q     <= offset_n;
			run_active_q <= run_active_n;
			run_start_q  <= run_start_n;
			run_len_q    <= run_len_n;
			run_chunks_q <= run_chunks_n;
		end
	end

	`ABMM_ASSERT_IMPLY(a_pos_in_ref, clk, arst_n, chunk_pos_q != '0, chunk_pos_q < ref_len_q, "chunk position beyond reference length")
	`ABMM_ASSERT_NEXT(a_scan_end_clear, clk, arst_n, fire && last && command == CMD_SCAN, chunk_pos_q == '0 && !run_active_q && offset_q == '0, "scan state not cleared after last byte")
	`ABMM_ASSERT_IMPLY(a_run_nonempty, clk, arst_n, run_active_q, run_chunks_q != '0 && run_len_q != '0, "active run without chunks")

endmodule

// ----- src/aligned_block_match_merger.sv -----
// top level: input register, match core, reference memory and result register
//
// channel  valid         stall         payload
// item     item_valid    item_stall    command, data_byte, last
// result   result_valid  result_stall  run_offset, run_size, run_blocks, scan_done, no_run
//
// one transaction per cycle while item_stall is low; a result passes through the
// input register, then the result register
// the reference byte for the next compare is prefetched into the memory's read register
// reset clears all control and scan state; the reference memory needs no clearing pass
// item_stall rises only while the result register holds an untaken result and the
// transaction in the input register has a result of its own
`include "aligned_block_match_merger_defines.svh"

module aligned_block_match_merger #(
	parameter int unsigned MAX_BLOCK = abmm_pkg::MAX_BLOCK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        command,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] run_offset,
	output logic [31:0] run_size,
	output logic [31:0] run_blocks,
	output logic        scan_done,
	output logic        no_run
);
	import abmm_pkg::*;

	localparam int unsigned ADDR_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);

	logic              valid_s1;
	logic              command_s1;
	logic [7:0]        data_byte_s1;
	logic              last_s1;
	logic              result_valid_q;
	res_t              res_q;

	logic              out_free;
	logic              fire;
	logic              has_result;
	res_t              res;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        ref_byte;

	assign out_free   = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && (!has_result || out_free);
	assign item_stall = valid_s1 && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			command_s1   <= command;
			data_byte_s1 <= data_byte;
			last_s1      <= last;
		end
	end

	abmm_match_core #(
		.MAX_BLOCK(MAX_BLOCK),
		.ADDR_W(ADDR_W),
		.CNT_W(CNT_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.present(valid_s1),
		.fire(fire),
		.command(command_s1),
		.data_byte(data_byte_s1),
		.last(last_s1),
		.ref_byte(ref_byte),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.has_result(has_result),
		.res(res)
	);

	abmm_ref_store #(
		.MAX_BLOCK(MAX_BLOCK),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(ref_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			res_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign run_offset   = res_q.run_offset;
	assign run_size     = res_q.run_size;
	assign run_blocks   = res_q.run_blocks;
	assign scan_done    = res_q.scan_done;
	assign no_run       = res_q.no_run;

	`ABMM_ASSERT_IMPLY(a_end_marker, clk, arst_n, result_valid_q && res_q.no_run, res_q.scan_done && res_q.run_offset == '0 && res_q.run_size == '0 && res_q.run_blocks == '0, "end marker carries run data")
	`ABMM_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, fire && has_result, !result_valid_q || !result_stall, "held result overwritten")
	`ABMM_ASSERT_NEXT(a_load_silent, clk, arst_n, fire && command_s1 == CMD_LOAD && out_free, !result_valid_q, "load transaction produced a result")

endmodule
